// File: hdl/rcsp_pkg.sv
// Shared definitions for the command stream parser: parser phases, error codes,
// register indexes, character codes and the fixed caps on count and length.
// No dependencies.
`timescale 1ns / 1ps

package rcsp_pkg;

  // fixed caps applied alongside the programmable limits; the smaller of the two counts
  localparam logic [31:0] ARGUMENT_CAP    = 32'd1024;
  localparam logic [31:0] BULK_LENGTH_CAP = 32'd16777216;

  // reset values of the limit registers
  localparam logic [10:0] ARGUMENT_LIMIT_RESET    = 11'd1024;
  localparam logic [24:0] BULK_LENGTH_LIMIT_RESET = 25'd16777216;

  // field widths
  localparam int unsigned ACC_W   = 25;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned CFG_INDEX_W = 8;

  // saturation value of the number accumulator
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ARGUMENT_LIMIT    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BULK_LENGTH_LIMIT = 8'd1;

  // character codes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_STAR     = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DATA_CR  = 4'd7,
    PH_DATA_LF  = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_STAR   = 3'd1,
    ERR_COUNT  = 3'd2,
    ERR_DOLLAR = 3'd3,
    ERR_LENGTH = 3'd4,
    ERR_CRLF   = 3'd5
  } error_t;

endpackage

// File: hdl/resp_command_stream_parser.sv
// Streaming parser for array-of-bulk-strings commands, one byte per request.
// Depends on rcsp_pkg for phases, error codes, character codes and caps.
// Single module: parser state, limit registers and one result register.
`timescale 1ns / 1ps

// The parser takes one stream byte per clock cycle and gives exactly one
// result per byte, in the cycle after the byte is accepted. The whole per-byte
// update (phase step, decimal accumulate by shift-and-add with saturation,
// limit compare, byte countdown) sits between the parser state registers and
// the result register, so a new byte is accepted in every cycle while the
// result side keeps up; when it stalls, the single result register holds and
// in_ready drops until that result is taken. Limit registers are written
// through the configuration channel, which is always ready; write them only
// while no result is pending. Once an error is latched every result repeats
// its code until a request with abort set returns the parser to its reset
// state.
module resp_command_stream_parser (
  input  logic                            clk,
  input  logic                            rst,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcsp_pkg::ACC_W-1:0]       cfg_data,
  // byte request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      stream_byte,
  input  logic                            abort,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            data_valid,
  output logic [7:0]                      data_byte,
  output logic [rcsp_pkg::INDEX_W-1:0]     argument_index,
  output logic                            argument_done,
  output logic                            command_done,
  output logic [rcsp_pkg::COUNT_W-1:0]     argument_count,
  output logic [2:0]                      error_code
);

  localparam int unsigned MUL_W = rcsp_pkg::ACC_W + 4;

  // limit registers
  logic [rcsp_pkg::COUNT_W-1:0] argument_limit;
  logic [rcsp_pkg::ACC_W-1:0]   bulk_length_limit;

  // parser state
  rcsp_pkg::phase_t             phase, phase_next;
  logic [rcsp_pkg::ACC_W-1:0]   number_accumulator, number_accumulator_next;
  logic                         saw_minus, saw_minus_next;
  logic                         saw_digit, saw_digit_next;
  logic [rcsp_pkg::COUNT_W-1:0] declared_arguments, declared_arguments_next;
  logic [rcsp_pkg::COUNT_W-1:0] current_argument, current_argument_next;
  logic [rcsp_pkg::ACC_W-1:0]   bytes_remaining, bytes_remaining_next;
  rcsp_pkg::error_t             error_latch, error_latch_next;

  // result values for this byte
  logic                         res_dv, res_adone, res_cdone;
  logic [7:0]                   res_db;
  logic [rcsp_pkg::COUNT_W-1:0] res_idx, res_acount;

  logic                         accept;
  logic                         is_digit;
  logic [3:0]                   digit;
  logic [MUL_W-1:0]             acc_times_ten;
  logic [rcsp_pkg::ACC_W-1:0]   acc_sat;
  logic                         count_over, length_over, number_over;
  logic                         number_bad;
  logic [rcsp_pkg::COUNT_W-1:0] next_argument;
  logic [rcsp_pkg::ACC_W-1:0]   remaining_dec;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // limit register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      argument_limit    <= rcsp_pkg::ARGUMENT_LIMIT_RESET;
      bulk_length_limit <= rcsp_pkg::BULK_LENGTH_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == rcsp_pkg::REG_ARGUMENT_LIMIT) begin
        argument_limit <= cfg_data[rcsp_pkg::COUNT_W-1:0];
      end else if (cfg_index == rcsp_pkg::REG_BULK_LENGTH_LIMIT) begin
        bulk_length_limit <= cfg_data;
      end
    end
  end

  // decimal accumulate: acc * 10 + digit, saturating
  assign is_digit = (stream_byte >= rcsp_pkg::CH_ZERO) && (stream_byte <= rcsp_pkg::CH_NINE);
  assign digit    = 4'(stream_byte - rcsp_pkg::CH_ZERO);
  assign acc_times_ten = {1'b0, number_accumulator, 3'b000}
                       + {3'b000, number_accumulator, 1'b0}
                       + {{(MUL_W-4){1'b0}}, digit};
  assign acc_sat = (acc_times_ten > {4'b0000, rcsp_pkg::ACC_MAX})
                 ? rcsp_pkg::ACC_MAX : acc_times_ten[rcsp_pkg::ACC_W-1:0];

  // limit checks against the smaller of register and cap
  assign count_over  = (number_accumulator > {14'b0, argument_limit})
                    || ({7'b0, number_accumulator} > rcsp_pkg::ARGUMENT_CAP);
  assign length_over = (number_accumulator > bulk_length_limit)
                    || ({7'b0, number_accumulator} > rcsp_pkg::BULK_LENGTH_CAP);
  assign number_over = (phase == rcsp_pkg::PH_COUNT) ? count_over : length_over;
  assign number_bad  = !saw_digit || (saw_minus && (number_accumulator != '0)) || number_over;

  assign next_argument = current_argument + {{(rcsp_pkg::COUNT_W-1){1'b0}}, 1'b1};
  assign remaining_dec = bytes_remaining - {{(rcsp_pkg::ACC_W-1){1'b0}}, 1'b1};

  // next state and result for one byte
  always_comb begin
    phase_next              = phase;
    number_accumulator_next = number_accumulator;
    saw_minus_next          = saw_minus;
    saw_digit_next          = saw_digit;
    declared_arguments_next = declared_arguments;
    current_argument_next   = current_argument;
    bytes_remaining_next    = bytes_remaining;
    error_latch_next        = error_latch;
    res_dv     = 1'b0;
    res_db     = 8'h00;
    res_idx    = current_argument;
    res_adone  = 1'b0;
    res_cdone  = 1'b0;
    res_acount = '0;

    if (abort) begin
      phase_next              = rcsp_pkg::PH_STAR;
      number_accumulator_next = '0;
      saw_minus_next          = 1'b0;
      saw_digit_next          = 1'b0;
      declared_arguments_next = '0;
      current_argument_next   = '0;
      bytes_remaining_next    = '0;
      error_latch_next        = rcsp_pkg::ERR_NONE;
      res_idx                 = '0;
    end else begin
      case (phase)
        rcsp_pkg::PH_STAR: begin
          if (stream_byte == rcsp_pkg::CH_STAR) begin
            number_accumulator_next = '0;
            saw_minus_next          = 1'b0;
            saw_digit_next          = 1'b0;
            phase_next              = rcsp_pkg::PH_COUNT;
          end else begin
            error_latch_next = rcsp_pkg::ERR_STAR;
            phase_next       = rcsp_pkg::PH_ERROR;
          end
        end
        rcsp_pkg::PH_COUNT, rcsp_pkg::PH_LEN: begin
          if (is_digit) begin
            number_accumulator_next = acc_sat;
            saw_digit_next          = 1'b1;
          end else if (stream_byte == rcsp_pkg::CH_MINUS && !saw_minus && !saw_digit) begin
            saw_minus_next = 1'b1;
          end else if (stream_byte == rcsp_pkg::CH_CR && !number_bad) begin
            phase_next = (phase == rcsp_pkg::PH_COUNT) ? rcsp_pkg::PH_COUNT_LF
                                                       : rcsp_pkg::PH_LEN_LF;
          end else begin
            error_latch_next = (phase == rcsp_pkg::PH_COUNT) ? rcsp_pkg::ERR_COUNT
                                                             : rcsp_pkg::ERR_LENGTH;
            phase_next       = rcsp_pkg::PH_ERROR;
          end
        end
        rcsp_pkg::PH_COUNT_LF: begin
          if (stream_byte != rcsp_pkg::CH_LF) begin
            error_latch_next = rcsp_pkg::ERR_COUNT;
            phase_next       = rcsp_pkg::PH_ERROR;
          end else begin
            declared_arguments_next = number_accumulator[rcsp_pkg::COUNT_W-1:0];
            current_argument_next   = '0;
            res_idx                 = '0;
            number_accumulator_next = '0;
            saw_minus_next          = 1'b0;
            saw_digit_next          = 1'b0;
            // an empty command completes right here
            if (number_accumulator[rcsp_pkg::COUNT_W-1:0] == '0) begin
              res_cdone  = 1'b1;
              phase_next = rcsp_pkg::PH_STAR;
            end else begin
              phase_next = rcsp_pkg::PH_DOLLAR;
            end
          end
        end
        rcsp_pkg::PH_DOLLAR: begin
          if (stream_byte == rcsp_pkg::CH_DOLLAR) begin
            number_accumulator_next = '0;
            saw_minus_next          = 1'b0;
            saw_digit_next          = 1'b0;
            phase_next              = rcsp_pkg::PH_LEN;
          end else begin
            error_latch_next = rcsp_pkg::ERR_DOLLAR;
            phase_next       = rcsp_pkg::PH_ERROR;
          end
        end
        rcsp_pkg::PH_LEN_LF: begin
          if (stream_byte != rcsp_pkg::CH_LF) begin
            error_latch_next = rcsp_pkg::ERR_LENGTH;
            phase_next       = rcsp_pkg::PH_ERROR;
          end else begin
            bytes_remaining_next    = number_accumulator;
            number_accumulator_next = '0;
            saw_minus_next          = 1'b0;
            saw_digit_next          = 1'b0;
            // zero length skips straight to the closing crlf
            phase_next = (number_accumulator != '0) ? rcsp_pkg::PH_DATA
                                                    : rcsp_pkg::PH_DATA_CR;
          end
        end
        rcsp_pkg::PH_DATA: begin
          res_dv               = 1'b1;
          res_db               = stream_byte;
          bytes_remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            phase_next = rcsp_pkg::PH_DATA_CR;
          end
        end
        rcsp_pkg::PH_DATA_CR: begin
          if (stream_byte == rcsp_pkg::CH_CR) begin
            phase_next = rcsp_pkg::PH_DATA_LF;
          end else begin
            error_latch_next = rcsp_pkg::ERR_CRLF;
            phase_next       = rcsp_pkg::PH_ERROR;
          end
        end
        rcsp_pkg::PH_DATA_LF: begin
          if (stream_byte != rcsp_pkg::CH_LF) begin
            error_latch_next = rcsp_pkg::ERR_CRLF;
            phase_next       = rcsp_pkg::PH_ERROR;
          end else begin
            res_adone = 1'b1;
            if (next_argument >= declared_arguments) begin
              res_cdone               = 1'b1;
              res_acount              = declared_arguments;
              current_argument_next   = '0;
              declared_arguments_next = '0;
              phase_next              = rcsp_pkg::PH_STAR;
            end else begin
              current_argument_next = next_argument;
              phase_next            = rcsp_pkg::PH_DOLLAR;
            end
          end
        end
        default: begin
          // error latched: byte ignored, code repeated
        end
      endcase
    end
  end

  // parser state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= rcsp_pkg::PH_STAR;
      number_accumulator <= '0;
      saw_minus          <= 1'b0;
      saw_digit          <= 1'b0;
      declared_arguments <= '0;
      current_argument   <= '0;
      bytes_remaining    <= '0;
      error_latch        <= rcsp_pkg::ERR_NONE;
    end else if (accept) begin
      phase              <= phase_next;
      number_accumulator <= number_accumulator_next;
      saw_minus          <= saw_minus_next;
      saw_digit          <= saw_digit_next;
      declared_arguments <= declared_arguments_next;
      current_argument   <= current_argument_next;
      bytes_remaining    <= bytes_remaining_next;
      error_latch        <= error_latch_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      data_valid     <= res_dv;
      data_byte      <= res_db;
      argument_index <= res_idx[rcsp_pkg::INDEX_W-1:0];
      argument_done  <= res_adone;
      command_done   <= res_cdone;
      argument_count <= res_acount;
      error_code     <= error_latch_next;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the command stream parser: byte requests with random
// gaps, result back-pressure, limit register writes and a per-byte predictor.
// Depends on rcsp_pkg and resp_command_stream_parser.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    logic                          data_valid;
    logic [7:0]                    data_byte;
    logic [rcsp_pkg::INDEX_W-1:0]  argument_index;
    logic                          argument_done;
    logic                          command_done;
    logic [rcsp_pkg::COUNT_W-1:0]  argument_count;
    logic [2:0]                    error_code;
  } parse_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rcsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rcsp_pkg::ACC_W-1:0]       cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       stream_byte = '0;
  logic                             abort = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             data_valid;
  logic [7:0]                       data_byte;
  logic [rcsp_pkg::INDEX_W-1:0]     argument_index;
  logic                             argument_done;
  logic                             command_done;
  logic [rcsp_pkg::COUNT_W-1:0]     argument_count;
  logic [2:0]                       error_code;

  resp_command_stream_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .stream_byte    (stream_byte),
    .abort          (abort),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_valid     (data_valid),
    .data_byte      (data_byte),
    .argument_index (argument_index),
    .argument_done  (argument_done),
    .command_done   (command_done),
    .argument_count (argument_count),
    .error_code     (error_code)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // parser image: limits and per-byte state
  logic [rcsp_pkg::COUNT_W-1:0] arg_limit_reg = rcsp_pkg::ARGUMENT_LIMIT_RESET;
  logic [rcsp_pkg::ACC_W-1:0]   len_limit_reg = rcsp_pkg::BULK_LENGTH_LIMIT_RESET;
  rcsp_pkg::phase_t             ps = rcsp_pkg::PH_STAR;
  logic [rcsp_pkg::ACC_W-1:0]   num_acc = '0;
  logic                         neg_seen = 1'b0;
  logic                         digit_seen = 1'b0;
  logic [rcsp_pkg::COUNT_W-1:0] arg_total = '0;
  logic [rcsp_pkg::COUNT_W-1:0] arg_cur = '0;
  logic [rcsp_pkg::ACC_W-1:0]   remaining = '0;
  rcsp_pkg::error_t             err_latched = rcsp_pkg::ERR_NONE;

  parse_result_t      expected_results[$];
  logic [7:0]         pending_bytes[$];
  int unsigned        mismatch_count = 0;
  int unsigned        items_sent = 0;
  bit                 no_gaps = 1'b0;

  function automatic longint unsigned count_cap();
    return (arg_limit_reg < rcsp_pkg::ARGUMENT_CAP) ? arg_limit_reg : rcsp_pkg::ARGUMENT_CAP;
  endfunction

  function automatic longint unsigned length_cap();
    return (len_limit_reg < rcsp_pkg::BULK_LENGTH_CAP) ? len_limit_reg
                                                        : rcsp_pkg::BULK_LENGTH_CAP;
  endfunction

  function automatic void clear_number();
    num_acc = '0;
    neg_seen = 1'b0;
    digit_seen = 1'b0;
  endfunction

  function automatic void raise_error(rcsp_pkg::error_t code);
    err_latched = code;
    ps = rcsp_pkg::PH_ERROR;
  endfunction

  // one byte of decimal text; returns 1 on an accepted CR
  function automatic bit number_step(logic [7:0] b, longint unsigned limit,
                                     rcsp_pkg::error_t code);
    longint unsigned v;
    if (b >= rcsp_pkg::CH_ZERO && b <= rcsp_pkg::CH_NINE) begin
      v = num_acc;
      v = v * 10 + (b - rcsp_pkg::CH_ZERO);
      num_acc = (v > rcsp_pkg::ACC_MAX) ? rcsp_pkg::ACC_MAX : v[rcsp_pkg::ACC_W-1:0];
      digit_seen = 1'b1;
    end else if (b == rcsp_pkg::CH_MINUS && !neg_seen && !digit_seen) begin
      neg_seen = 1'b1;
    end else if (b == rcsp_pkg::CH_CR) begin
      if (!digit_seen || (neg_seen && num_acc != 0) || num_acc > limit) begin
        raise_error(code);
      end else begin
        return 1'b1;
      end
    end else begin
      raise_error(code);
    end
    return 1'b0;
  endfunction

  // advance the parser image by one accepted request
  function automatic parse_result_t predict_byte(logic [7:0] b, logic ab);
    parse_result_t r;
    logic [rcsp_pkg::COUNT_W-1:0] idx;
    r = '0;
    if (ab) begin
      ps = rcsp_pkg::PH_STAR;
      clear_number();
      arg_total = '0;
      arg_cur = '0;
      remaining = '0;
      err_latched = rcsp_pkg::ERR_NONE;
      return r;
    end
    idx = arg_cur;
    case (ps)
      rcsp_pkg::PH_STAR: begin
        if (b == rcsp_pkg::CH_STAR) begin
          clear_number();
          ps = rcsp_pkg::PH_COUNT;
        end else begin
          raise_error(rcsp_pkg::ERR_STAR);
        end
      end
      rcsp_pkg::PH_COUNT: begin
        if (number_step(b, count_cap(), rcsp_pkg::ERR_COUNT)) ps = rcsp_pkg::PH_COUNT_LF;
      end
      rcsp_pkg::PH_COUNT_LF: begin
        if (b != rcsp_pkg::CH_LF) begin
          raise_error(rcsp_pkg::ERR_COUNT);
        end else begin
          arg_total = num_acc[rcsp_pkg::COUNT_W-1:0];
          arg_cur = '0;
          idx = '0;
          clear_number();
          if (arg_total == 0) begin
            r.command_done = 1'b1;
            ps = rcsp_pkg::PH_STAR;
          end else begin
            ps = rcsp_pkg::PH_DOLLAR;
          end
        end
      end
      rcsp_pkg::PH_DOLLAR: begin
        if (b == rcsp_pkg::CH_DOLLAR) begin
          clear_number();
          ps = rcsp_pkg::PH_LEN;
        end else begin
          raise_error(rcsp_pkg::ERR_DOLLAR);
        end
      end
      rcsp_pkg::PH_LEN: begin
        if (number_step(b, length_cap(), rcsp_pkg::ERR_LENGTH)) ps = rcsp_pkg::PH_LEN_LF;
      end
      rcsp_pkg::PH_LEN_LF: begin
        if (b != rcsp_pkg::CH_LF) begin
          raise_error(rcsp_pkg::ERR_LENGTH);
        end else begin
          remaining = num_acc;
          clear_number();
          ps = (remaining != 0) ? rcsp_pkg::PH_DATA : rcsp_pkg::PH_DATA_CR;
        end
      end
      rcsp_pkg::PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte = b;
        remaining = remaining - {{(rcsp_pkg::ACC_W-1){1'b0}}, 1'b1};
        if (remaining == 0) ps = rcsp_pkg::PH_DATA_CR;
      end
      rcsp_pkg::PH_DATA_CR: begin
        if (b == rcsp_pkg::CH_CR) ps = rcsp_pkg::PH_DATA_LF;
        else raise_error(rcsp_pkg::ERR_CRLF);
      end
      rcsp_pkg::PH_DATA_LF: begin
        if (b != rcsp_pkg::CH_LF) begin
          raise_error(rcsp_pkg::ERR_CRLF);
        end else begin
          r.argument_done = 1'b1;
          arg_cur = arg_cur + {{(rcsp_pkg::COUNT_W-1){1'b0}}, 1'b1};
          if (arg_cur >= arg_total) begin
            r.command_done = 1'b1;
            r.argument_count = arg_total;
            arg_cur = '0;
            arg_total = '0;
            ps = rcsp_pkg::PH_STAR;
          end else begin
            ps = rcsp_pkg::PH_DOLLAR;
          end
        end
      end
      default: begin
      end
    endcase
    r.argument_index = idx[rcsp_pkg::INDEX_W-1:0];
    r.error_code = err_latched;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic compare_field(string what, longint unsigned got, longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // result checking, then prediction of the request taken at this edge
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          compare_field("data_valid", data_valid, want.data_valid);
          compare_field("data_byte", data_byte, want.data_byte);
          compare_field("argument_index", argument_index, want.argument_index);
          compare_field("argument_done", argument_done, want.argument_done);
          compare_field("command_done", command_done, want.command_done);
          compare_field("argument_count", argument_count, want.argument_count);
          compare_field("error_code", error_code, want.error_code);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_byte(stream_byte, abort));
    end
  end

  // result side back-pressure
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    int unsigned n;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      n = no_gaps ? 0 : $urandom_range(0, 3);
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= n - 1;
      end
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // watchdog on cycles without any request, result or configuration handshake
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte request, with a random lead-in gap unless no_gaps is set
  task automatic send_request(logic [7:0] b, logic ab);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    abort <= ab;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_pending();
    while (pending_bytes.size() != 0) send_request(pending_bytes.pop_front(), 1'b0);
  endtask

  task automatic send_abort();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold off until every pending result has come back
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // both limit registers, back to back
  task automatic write_limits(logic [rcsp_pkg::COUNT_W-1:0] arg_lim,
                              logic [rcsp_pkg::ACC_W-1:0] len_lim);
    cfg_valid <= 1'b1;
    cfg_index <= rcsp_pkg::REG_ARGUMENT_LIMIT;
    cfg_data <= rcsp_pkg::ACC_W'(arg_lim);
    do @(posedge clk); while (!cfg_ready);
    arg_limit_reg = arg_lim;
    cfg_index <= rcsp_pkg::REG_BULK_LENGTH_LIMIT;
    cfg_data <= len_lim;
    do @(posedge clk); while (!cfg_ready);
    len_limit_reg = len_lim;
    cfg_valid <= 1'b0;
  endtask

  // byte stream builders
  function automatic void add_byte(logic [7:0] b);
    pending_bytes.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_decimal(longint unsigned v);
    add_text($sformatf("%0d", v));
  endfunction

  // decimal with an occasional leading zero or minus zero
  function automatic void add_number(longint unsigned v);
    int unsigned style;
    style = $urandom_range(0, 7);
    if (style == 0) add_byte(rcsp_pkg::CH_ZERO);
    if (style == 1 && v == 0) add_byte(rcsp_pkg::CH_MINUS);
    add_decimal(v);
  endfunction

  function automatic void add_crlf();
    add_byte(rcsp_pkg::CH_CR);
    add_byte(rcsp_pkg::CH_LF);
  endfunction

  function automatic void add_command(int unsigned nargs, int unsigned maxlen);
    int unsigned len;
    add_byte(rcsp_pkg::CH_STAR);
    add_number(nargs);
    add_crlf();
    for (int i = 0; i < nargs; i++) begin
      len = $urandom_range(0, maxlen);
      add_byte(rcsp_pkg::CH_DOLLAR);
      add_number(len);
      add_crlf();
      repeat (len) add_byte(8'($urandom_range(0, 255)));
      add_crlf();
    end
  endfunction

  function automatic void add_legal_command();
    int unsigned nmax, lmax;
    nmax = 32'((count_cap() < 4) ? count_cap() : 4);
    lmax = 32'((length_cap() < 12) ? length_cap() : 12);
    if ($urandom_range(0, 7) == 0) lmax = 32'((length_cap() < 60) ? length_cap() : 60);
    add_command($urandom_range(0, nmax), lmax);
  endfunction

  function automatic logic [7:0] pick_bad_byte();
    case ($urandom_range(0, 6))
      0: return rcsp_pkg::CH_MINUS;
      1: return rcsp_pkg::CH_CR;
      2: return rcsp_pkg::CH_LF;
      3: return rcsp_pkg::CH_STAR;
      4: return rcsp_pkg::CH_DOLLAR;
      5: return 8'(rcsp_pkg::CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one command, legal or damaged; damaged ones are followed by an abort
  task automatic random_command();
    int unsigned kind, pos, keep;
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      add_legal_command();
      send_pending();
      if ($urandom_range(0, 24) == 0) send_abort();
    end else if (kind < 16) begin
      add_legal_command();
      pos = $urandom_range(0, pending_bytes.size() - 1);
      pending_bytes[pos] = pick_bad_byte();
      send_pending();
      send_abort();
    end else if (kind == 16) begin
      if ($urandom_range(0, 1)) begin
        add_byte(rcsp_pkg::CH_STAR);
        add_decimal(count_cap() + $urandom_range(1, 3));
      end else begin
        add_text("*1\r\n$");
        add_decimal(length_cap() + $urandom_range(1, 3));
      end
      add_byte(rcsp_pkg::CH_CR);
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
      send_pending();
      send_abort();
    end else if (kind == 17) begin
      add_legal_command();
      keep = $urandom_range(1, pending_bytes.size());
      while (pending_bytes.size() > keep) void'(pending_bytes.pop_back());
      send_pending();
      send_abort();
    end else begin
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
      send_pending();
      send_abort();
    end
  endtask

  task automatic random_phase(logic [rcsp_pkg::COUNT_W-1:0] arg_lim,
                              logic [rcsp_pkg::ACC_W-1:0] len_lim,
                              int unsigned budget);
    int unsigned start;
    bit paused;
    wait_until_idle();
    write_limits(arg_lim, len_lim);
    start = items_sent;
    paused = 1'b0;
    while (items_sent < start + budget) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      random_command();
      if (!paused && items_sent >= start + budget / 2) begin
        paused = 1'b1;
        wait_until_idle();
      end
    end
    no_gaps = 1'b0;
  endtask

  // legal commands: zero count, minus zero, zero length, leading zeros, payload extremes
  task automatic test_well_formed();
    add_text("*0\r\n*-0\r\n*1\r\n$0\r\n\r\n");
    add_text("*2\r\n$4\r\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(rcsp_pkg::CH_CR);
    add_byte(rcsp_pkg::CH_STAR);
    add_text("\r\n$002\r\nab\r\n");
    send_pending();
  endtask

  // malformed numbers in count and length
  task automatic test_number_errors();
    string cases[11];
    cases = '{"*\r", "*-\r", "*--", "*3-", "*-2\r", "*1x", "*1\r\r",
              "*1\r\n$\r", "*1\r\n$-5\r", "*1\r\n$99999999999\r", "*99999999\r"};
    foreach (cases[i]) begin
      add_text(cases[i]);
      add_text("zz");
      send_pending();
      send_abort();
    end
  endtask

  // missing markers and CRLF, sticky errors, abort mid-payload
  task automatic test_framing_errors();
    string cases[4];
    cases = '{"x*1\r\n", "*1\r\n#", "*1\r\n$2\r\nab\n", "*1\r\n$1\r\na\rx"};
    foreach (cases[i]) begin
      add_text(cases[i]);
      add_text("$0\r\n");
      send_pending();
      send_abort();
    end
    add_text("*1\r\n$5\r\nab");
    send_pending();
    send_abort();
    add_text("*1\r\n$1\r\nq\r\n");
    send_pending();
  endtask

  // limit extremes and values just past them
  task automatic test_limits();
    wait_until_idle();
    write_limits('0, '0);
    add_text("*0\r\n*1\r");
    send_pending();
    send_abort();
    wait_until_idle();
    write_limits(11'd2, 25'd3);
    add_text("*2\r\n$3\r\nabc\r\n$0\r\n\r\n*3\r");
    send_pending();
    send_abort();
    add_text("*1\r\n$4\r");
    send_pending();
    send_abort();
    wait_until_idle();
    write_limits(rcsp_pkg::ARGUMENT_LIMIT_RESET, rcsp_pkg::BULK_LENGTH_LIMIT_RESET);
    add_text("*1024\r\n$16777216\r\n");
    repeat (4) add_byte(8'($urandom_range(0, 255)));
    send_pending();
    send_abort();
    add_text("*1025\r");
    send_pending();
    send_abort();
    add_text("*1\r\n$16777217\r");
    send_pending();
    send_abort();
  endtask

  task automatic test_random_traffic();
    random_phase(rcsp_pkg::ARGUMENT_LIMIT_RESET, rcsp_pkg::BULK_LENGTH_LIMIT_RESET, 330);
    random_phase(11'($urandom_range(1, 6)), 25'($urandom_range(1, 24)), 330);
    random_phase('0, '0, 80);
    random_phase(11'($urandom_range(0, 1024)), 25'($urandom_range(0, 40)), 310);
  endtask

  // sequence of tests
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_well_formed();
    test_number_errors();
    test_framing_errors();
    test_limits();
    test_random_traffic();
    wait_until_idle();
    if (expected_results.size() != 0)
      report_mismatch("results still pending", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
